@@ hw/rtl/uart_rae_pkg.sv @@
// Shared types and constants for the UART register access engine.
package uart_rae_pkg;

	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned FrameMax = 8;
	localparam int unsigned FrameCntW = $clog2(FrameMax + 1);

	localparam logic [7:0]  AddrMask     = 8'h7F;
	localparam logic [15:0] TickSat      = 16'hFFFF;
	localparam logic [15:0] TimeoutReset = 16'd100;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_RX    = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_RD_CSUM = 2'd2,
		ST_WR_ACK  = 2'd3
	} status_t;

	typedef enum logic {
		KIND_TX   = 1'b0,
		KIND_DONE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_READ  = 2'd1,
		PH_WRITE = 2'd2
	} phase_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_CSUM_BASE = 2'd0,
		CFG_HEADER    = 2'd1,
		CFG_WR_CMD    = 2'd2,
		CFG_TIMEOUT   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic               we;
		logic [CfgIdxW-1:0] idx;
		logic [CfgDataW-1:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  command_code;
		logic [7:0]  reg_addr;
		logic [31:0] write_data;
		logic [7:0]  rx_byte;
	} req_item_t;

	// What one request leaves for the output side: a frame of bytes or one finish beat
	typedef struct packed {
		logic                 has;
		kind_t                kind;
		logic [FrameCntW-1:0] len;
		logic [FrameMax-1:0][7:0] bytes;
		logic [31:0]          value;
		status_t              status;
	} txn_res_t;

	function automatic logic [7:0] make_csum(logic [7:0] base, logic [7:0] sum);
		return base + ~sum;
	endfunction

endpackage

@@ hw/rtl/uart_rae_if.sv @@
// Valid/ready channel interfaces for request and response beats.
interface uart_rae_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  command_code;
	logic [7:0]  reg_addr;
	logic [31:0] write_data;
	logic [7:0]  rx_byte;

	modport source (output valid, cmd, command_code, reg_addr, write_data, rx_byte,
		input ready);
	modport sink (input valid, cmd, command_code, reg_addr, write_data, rx_byte,
		output ready);
endinterface

interface uart_rae_rsp_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  tx_byte;
	logic [31:0] read_value;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, kind, tx_byte, read_value, status, last, input ready);
	modport sink (input valid, kind, tx_byte, read_value, status, last, output ready);
endinterface

@@ hw/rtl/uart_rae_txn.sv @@
// Transaction sequencer: protocol state, config registers and per-request results.
module uart_rae_txn (
	input  logic                    clk,
	input  logic                    arst_n,
	input  uart_rae_pkg::cfg_wr_t   cfg,
	input  uart_rae_pkg::req_item_t item,
	input  logic                    go,
	output uart_rae_pkg::txn_res_t  res
);

	logic [7:0]  csum_base_q;
	logic [7:0]  header_q;
	logic [7:0]  wr_cmd_q;
	logic [15:0] timeout_q;

	uart_rae_pkg::phase_t phase_q, phase_d;
	logic [2:0]  bcnt_q, bcnt_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  ack_q, ack_d;
	logic [31:0] acc_q, acc_d;
	logic [15:0] wait_q, wait_d;

	logic [7:0]  addr7;
	logic [7:0]  rd_sum;
	logic [7:0]  wr_sum;
	logic [15:0] wait_inc;
	logic        tmo_hit;
	uart_rae_pkg::cmd_t cmd;

	assign cmd      = uart_rae_pkg::cmd_t'(item.cmd);
	assign addr7    = item.reg_addr & uart_rae_pkg::AddrMask;
	assign rd_sum   = item.command_code + addr7;
	assign wr_sum   = wr_cmd_q + addr7 + item.write_data[7:0] + item.write_data[15:8]
		+ item.write_data[23:16] + item.write_data[31:24];
	assign wait_inc = (wait_q != uart_rae_pkg::TickSat) ? wait_q + 16'd1 : wait_q;
	assign tmo_hit  = (wait_inc >= timeout_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csum_base_q <= '0;
			header_q    <= '0;
			wr_cmd_q    <= '0;
			timeout_q   <= uart_rae_pkg::TimeoutReset;
		end else if (cfg.we) begin
			unique case (uart_rae_pkg::cfg_idx_t'(cfg.idx))
				uart_rae_pkg::CFG_CSUM_BASE: csum_base_q <= cfg.wdata[7:0];
				uart_rae_pkg::CFG_HEADER:    header_q    <= cfg.wdata[7:0];
				uart_rae_pkg::CFG_WR_CMD:    wr_cmd_q    <= cfg.wdata[7:0];
				uart_rae_pkg::CFG_TIMEOUT:   timeout_q   <= cfg.wdata[15:0];
			endcase
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		bcnt_d  = bcnt_q;
		sum_d   = sum_q;
		ack_d   = ack_q;
		acc_d   = acc_q;
		wait_d  = wait_q;
		unique case (cmd)
			uart_rae_pkg::CMD_READ: begin
				if (phase_q == uart_rae_pkg::PH_IDLE) begin
					phase_d = uart_rae_pkg::PH_READ;
					sum_d   = rd_sum;
					bcnt_d  = '0;
					acc_d   = '0;
					wait_d  = '0;
				end
			end
			uart_rae_pkg::CMD_WRITE: begin
				if (phase_q == uart_rae_pkg::PH_IDLE) begin
					phase_d = uart_rae_pkg::PH_WRITE;
					ack_d   = uart_rae_pkg::make_csum(csum_base_q, wr_sum);
					wait_d  = '0;
				end
			end
			uart_rae_pkg::CMD_RX: begin
				if (phase_q == uart_rae_pkg::PH_READ && !bcnt_q[2]) begin
					unique case (bcnt_q[1:0])
						2'd0: acc_d[7:0]   = item.rx_byte;
						2'd1: acc_d[15:8]  = item.rx_byte;
						2'd2: acc_d[23:16] = item.rx_byte;
						2'd3: acc_d[31:24] = item.rx_byte;
					endcase
					sum_d  = sum_q + item.rx_byte;
					bcnt_d = bcnt_q + 3'd1;
				end else if (phase_q != uart_rae_pkg::PH_IDLE) begin
					phase_d = uart_rae_pkg::PH_IDLE;
					bcnt_d  = '0;
					sum_d   = '0;
					ack_d   = '0;
					acc_d   = '0;
					wait_d  = '0;
				end
			end
			uart_rae_pkg::CMD_TICK: begin
				if (phase_q != uart_rae_pkg::PH_IDLE) begin
					if (tmo_hit) begin
						phase_d = uart_rae_pkg::PH_IDLE;
						bcnt_d  = '0;
						sum_d   = '0;
						ack_d   = '0;
						acc_d   = '0;
						wait_d  = '0;
					end else begin
						wait_d = wait_inc;
					end
				end
			end
		endcase
	end

	// results
	always_comb begin
		res        = '0;
		res.kind   = uart_rae_pkg::KIND_TX;
		res.status = uart_rae_pkg::ST_OK;
		unique case (cmd)
			uart_rae_pkg::CMD_READ: begin
				if (phase_q == uart_rae_pkg::PH_IDLE) begin
					res.has      = 1'b1;
					res.len      = uart_rae_pkg::FrameCntW'(4);
					res.bytes[0] = header_q;
					res.bytes[1] = item.command_code;
					res.bytes[2] = addr7;
					res.bytes[3] = uart_rae_pkg::make_csum(csum_base_q, rd_sum);
				end
			end
			uart_rae_pkg::CMD_WRITE: begin
				if (phase_q == uart_rae_pkg::PH_IDLE) begin
					res.has      = 1'b1;
					res.len      = uart_rae_pkg::FrameCntW'(8);
					res.bytes[0] = header_q;
					res.bytes[1] = wr_cmd_q;
					res.bytes[2] = addr7;
					res.bytes[3] = item.write_data[7:0];
					res.bytes[4] = item.write_data[15:8];
					res.bytes[5] = item.write_data[23:16];
					res.bytes[6] = item.write_data[31:24];
					res.bytes[7] = uart_rae_pkg::make_csum(csum_base_q, wr_sum);
				end
			end
			uart_rae_pkg::CMD_RX: begin
				if (phase_q == uart_rae_pkg::PH_READ && bcnt_q[2]) begin
					res.has  = 1'b1;
					res.kind = uart_rae_pkg::KIND_DONE;
					res.len  = uart_rae_pkg::FrameCntW'(1);
					if (item.rx_byte == uart_rae_pkg::make_csum(csum_base_q, sum_q)) begin
						res.value = acc_q;
					end else begin
						res.status = uart_rae_pkg::ST_RD_CSUM;
					end
				end else if (phase_q == uart_rae_pkg::PH_WRITE) begin
					res.has    = 1'b1;
					res.kind   = uart_rae_pkg::KIND_DONE;
					res.len    = uart_rae_pkg::FrameCntW'(1);
					res.status = (item.rx_byte == ack_q) ? uart_rae_pkg::ST_OK
						: uart_rae_pkg::ST_WR_ACK;
				end
			end
			uart_rae_pkg::CMD_TICK: begin
				if (phase_q != uart_rae_pkg::PH_IDLE && tmo_hit) begin
					res.has    = 1'b1;
					res.kind   = uart_rae_pkg::KIND_DONE;
					res.len    = uart_rae_pkg::FrameCntW'(1);
					res.status = uart_rae_pkg::ST_TIMEOUT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uart_rae_pkg::PH_IDLE;
			bcnt_q  <= '0;
			sum_q   <= '0;
			ack_q   <= '0;
			acc_q   <= '0;
			wait_q  <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			bcnt_q  <= bcnt_d;
			sum_q   <= sum_d;
			ack_q   <= ack_d;
			acc_q   <= acc_d;
			wait_q  <= wait_d;
		end
	end

endmodule

@@ hw/rtl/afe_uart_register_access_engine_unit.sv @@
// Top level of the UART register access engine: input stage, sequencer, output frame buffer.
//
// Usage:
//   req carries one request beat: start read, start write, received byte or time tick.
//   rsp carries result beats: frame bytes to transmit (kind 0, last on the checksum byte)
//   or one finish beat (kind 1) with read value and status.
//   The user writes the config registers (checksum base, header, write command, timeout)
//   via cfg_we/cfg_idx/cfg_wdata only while the engine is idle; the block does not check.
// Timing: a request is registered on acceptance and evaluated in the next cycle; with the
//   frame buffer free its result frame is loaded into the frame buffer, whose slot 0 is rsp.
// Throughput: requests that produce no results (received data bytes, ticks, ignored
//   requests) are taken every cycle, unless one with results waits in the input stage until
//   the frame buffer is empty or emptying; a frame of N bytes occupies rsp for N beats, so a
//   read start costs 4 beats, a write start 8, a finish 1. The frame buffer's drain sets this.
// Reset: clears the protocol state to idle, empties both stages, and restores the config
//   registers (timeout 100 ticks, others 0).
// Stall: when rsp is not ready the current beat holds and the frame buffer stops shifting;
//   req keeps taking items that produce no results, then backs up behind the input stage.
module afe_uart_register_access_engine_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	uart_rae_req_if.sink                      req,
	uart_rae_rsp_if.source                    rsp,
	input  logic                              cfg_we,
	input  logic [uart_rae_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [uart_rae_pkg::CfgDataW-1:0] cfg_wdata
);

	logic                    s1_valid_q;
	uart_rae_pkg::req_item_t item_s1;
	uart_rae_pkg::txn_res_t  res;
	uart_rae_pkg::cfg_wr_t   cfg;

	logic [uart_rae_pkg::FrameMax-1:0][7:0]  fb_byte_q;
	logic [uart_rae_pkg::FrameCntW-1:0]      fb_cnt_q;
	uart_rae_pkg::kind_t     fb_kind_q;
	logic [31:0]             fb_val_q;
	uart_rae_pkg::status_t   fb_st_q;

	logic rsp_beat;
	logic fb_room;
	logic s1_adv;
	logic fb_load;

	assign cfg = '{we: cfg_we, idx: cfg_idx, wdata: cfg_wdata};

	assign rsp_beat  = rsp.valid && rsp.ready;
	assign fb_room   = (fb_cnt_q == '0)
		|| (fb_cnt_q == uart_rae_pkg::FrameCntW'(1) && rsp.ready);
	assign s1_adv    = s1_valid_q && (!res.has || fb_room);
	assign fb_load   = s1_adv && res.has;
	assign req.ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.cmd          <= req.cmd;
			item_s1.command_code <= req.command_code;
			item_s1.reg_addr     <= req.reg_addr;
			item_s1.write_data   <= req.write_data;
			item_s1.rx_byte      <= req.rx_byte;
		end
	end

	uart_rae_txn u_txn (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.go     (s1_adv),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_cnt_q <= '0;
		end else if (fb_load) begin
			fb_cnt_q <= res.len;
		end else if (rsp_beat) begin
			fb_cnt_q <= fb_cnt_q - uart_rae_pkg::FrameCntW'(1);
		end
	end

	// frame bytes shift toward slot 0, which is the beat on rsp
	always_ff @(posedge clk) begin
		if (fb_load) begin
			fb_byte_q <= res.bytes;
			fb_kind_q <= res.kind;
			fb_val_q  <= res.value;
			fb_st_q   <= res.status;
		end else if (rsp_beat) begin
			fb_byte_q <= {8'h00, fb_byte_q[uart_rae_pkg::FrameMax-1:1]};
		end
	end

	assign rsp.valid      = (fb_cnt_q != '0);
	assign rsp.kind       = fb_kind_q;
	assign rsp.tx_byte    = fb_byte_q[0];
	assign rsp.read_value = fb_val_q;
	assign rsp.status     = fb_st_q;
	assign rsp.last       = (fb_kind_q == uart_rae_pkg::KIND_TX)
		&& (fb_cnt_q == uart_rae_pkg::FrameCntW'(1));

endmodule

@@ hw/rtl/uart_rae_chk.sv @@
// Port-level checker for the UART register access engine, bound to the top level.
module uart_rae_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_kind,
	input logic [7:0]  rsp_tx_byte,
	input logic [31:0] rsp_read_value,
	input logic [1:0]  rsp_status,
	input logic        rsp_last
);

	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("response beat during reset");

	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind |-> !rsp_last && rsp_tx_byte == 8'h00
			&& (rsp_status == uart_rae_pkg::ST_OK || rsp_read_value == 32'h0))
		else $error("malformed finish beat");

	a_tx_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_kind |-> rsp_read_value == 32'h0
			&& rsp_status == uart_rae_pkg::ST_OK)
		else $error("frame beat carries value or status");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_tx_byte)
			&& $stable(rsp_read_value) && $stable(rsp_status) && $stable(rsp_last))
		else $error("stalled response beat changed");

endmodule

bind afe_uart_register_access_engine_unit uart_rae_chk u_uart_rae_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_kind       (rsp.kind),
	.rsp_tx_byte    (rsp.tx_byte),
	.rsp_read_value (rsp.read_value),
	.rsp_status     (rsp.status),
	.rsp_last       (rsp.last)
);

@@ bench/tb_afe_uart_register_access_engine_unit.sv @@
// Self-checking bench for the UART register access engine: random framed traffic vs. a scoreboard.
module tb_afe_uart_register_access_engine_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import uart_rae_pkg::*;

	localparam int unsigned CycleLimit = 1_000_000;
	localparam int unsigned SettleCycles = 4;

	// One response beat, kept 4-state so an X on the port shows up as a mismatch
	typedef struct packed {
		logic        kind;
		logic [7:0]  tx_byte;
		logic [31:0] read_value;
		logic [1:0]  status;
		logic        last;
	} rae_beat_t;

	class rae_scoreboard;
		logic [7:0]  csum_base;
		logic [7:0]  header;
		logic [7:0]  wr_cmd;
		logic [15:0] timeout;
		phase_t      ph;
		logic [2:0]  nbytes;
		logic [7:0]  run_sum;
		logic [7:0]  ack;
		logic [31:0] accum;
		logic [15:0] wait_ticks;
		rae_beat_t   frame_beats[$];
		int          errors;

		function new();
			errors = 0;
			csum_base = '0;
			header = '0;
			wr_cmd = '0;
			timeout = 16'd100;
			clear_txn();
		endfunction

		function void clear_txn();
			ph = PH_IDLE;
			nbytes = '0;
			run_sum = '0;
			ack = '0;
			accum = '0;
			wait_ticks = '0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [15:0] v);
			case (idx)
			CFG_CSUM_BASE: csum_base = v[7:0];
			CFG_HEADER:    header = v[7:0];
			CFG_WR_CMD:    wr_cmd = v[7:0];
			CFG_TIMEOUT:   timeout = v;
			default: ;
			endcase
		endfunction

		function logic [7:0] frame_csum(logic [7:0] s);
			logic [7:0] inv;
			inv = ~s;
			return csum_base + inv;
		endfunction

		function void push_beat(logic k, logic [7:0] b, logic [31:0] v, logic [1:0] st, logic l);
			rae_beat_t e;
			e.kind = k;
			e.tx_byte = b;
			e.read_value = v;
			e.status = st;
			e.last = l;
			frame_beats.push_back(e);
		endfunction

		function void note_request(req_item_t it);
			logic [7:0] addr;
			logic [7:0] sum;
			logic [7:0] b;
			int i;
			addr = {1'b0, it.reg_addr[6:0]};
			case (cmd_t'(it.cmd))
			CMD_READ: if (ph == PH_IDLE) begin
				run_sum = it.command_code + addr;
				push_beat(KIND_TX, header, '0, ST_OK, 1'b0);
				push_beat(KIND_TX, it.command_code, '0, ST_OK, 1'b0);
				push_beat(KIND_TX, addr, '0, ST_OK, 1'b0);
				push_beat(KIND_TX, frame_csum(run_sum), '0, ST_OK, 1'b1);
				ph = PH_READ;
				nbytes = '0;
				accum = '0;
				wait_ticks = '0;
			end
			CMD_WRITE: if (ph == PH_IDLE) begin
				sum = wr_cmd + addr;
				push_beat(KIND_TX, header, '0, ST_OK, 1'b0);
				push_beat(KIND_TX, wr_cmd, '0, ST_OK, 1'b0);
				push_beat(KIND_TX, addr, '0, ST_OK, 1'b0);
				for (i = 0; i < 4; i++) begin
					b = it.write_data[8*i +: 8];
					sum = sum + b;
					push_beat(KIND_TX, b, '0, ST_OK, 1'b0);
				end
				ack = frame_csum(sum);
				push_beat(KIND_TX, ack, '0, ST_OK, 1'b1);
				ph = PH_WRITE;
				wait_ticks = '0;
			end
			CMD_RX: begin
				if (ph == PH_READ) begin
					if (nbytes < 3'd4) begin
						accum = accum | ({24'd0, it.rx_byte} << (8 * nbytes));
						run_sum = run_sum + it.rx_byte;
						nbytes = nbytes + 3'd1;
					end else begin
						if (it.rx_byte == frame_csum(run_sum))
							push_beat(KIND_DONE, '0, accum, ST_OK, 1'b0);
						else
							push_beat(KIND_DONE, '0, '0, ST_RD_CSUM, 1'b0);
						clear_txn();
					end
				end else if (ph == PH_WRITE) begin
					push_beat(KIND_DONE, '0, '0, (it.rx_byte == ack) ? ST_OK : ST_WR_ACK, 1'b0);
					clear_txn();
				end
			end
			CMD_TICK: if (ph != PH_IDLE) begin
				// counter saturates; a timeout of zero fires on the first tick
				if (wait_ticks != 16'hFFFF)
					wait_ticks = wait_ticks + 16'd1;
				if (wait_ticks >= timeout) begin
					push_beat(KIND_DONE, '0, '0, ST_TIMEOUT, 1'b0);
					clear_txn();
				end
			end
			default: ;
			endcase
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("%0t: mismatch on %s: expected %h, actual %h", $time, field, want, got);
		endfunction

		function void check_beat(rae_beat_t got);
			rae_beat_t want;
			if (frame_beats.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat: expected none, actual %h", $time, got);
				return;
			end
			want = frame_beats.pop_front();
			if (got.kind !== want.kind)
				report("kind", 32'(want.kind), 32'(got.kind));
			if (got.tx_byte !== want.tx_byte)
				report("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
			if (got.read_value !== want.read_value)
				report("read_value", want.read_value, got.read_value);
			if (got.status !== want.status)
				report("status", 32'(want.status), 32'(got.status));
			if (got.last !== want.last)
				report("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [CfgIdxW-1:0]  cfg_idx;
	logic [CfgDataW-1:0] cfg_wdata;
	int unsigned idle_mode;  // 0 none, 1 sender idle, 2 receiver stall, 3 both light
	int unsigned cycle_count;

	rae_scoreboard sb = new();

	uart_rae_req_if req_ch ();
	uart_rae_rsp_if rsp_ch ();

	afe_uart_register_access_engine_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("afe_uart_register_access_engine_unit test failed");
		$finish;
	end

	// Response side: check every accepted beat, then pick next ready
	initial begin
		rae_beat_t got;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.kind = rsp_ch.kind;
				got.tx_byte = rsp_ch.tx_byte;
				got.read_value = rsp_ch.read_value;
				got.status = rsp_ch.status;
				got.last = rsp_ch.last;
				sb.check_beat(got);
			end
			case (idle_mode)
			2:       rsp_ch.ready <= ($urandom_range(0, 99) >= 84);
			3:       rsp_ch.ready <= ($urandom_range(0, 99) >= 19);
			default: rsp_ch.ready <= 1'b1;
			endcase
		end
	end

	function automatic req_item_t rand_req(cmd_t c);
		req_item_t it;
		it.cmd = c;
		it.command_code = 8'($urandom);
		it.reg_addr = 8'($urandom);
		it.write_data = $urandom;
		it.rx_byte = 8'($urandom);
		return it;
	endfunction

	function automatic bit sender_gap();
		case (idle_mode)
		1:       return ($urandom_range(0, 99) < 84);
		3:       return ($urandom_range(0, 99) < 19);
		default: return 1'b0;
		endcase
	endfunction

	// Called at a clock edge; returns at the edge where the beat is taken
	task automatic send_item(req_item_t it);
		while (sender_gap()) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= it.cmd;
		req_ch.command_code <= it.command_code;
		req_ch.reg_addr <= it.reg_addr;
		req_ch.write_data <= it.write_data;
		req_ch.rx_byte <= it.rx_byte;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		sb.note_request(it);
	endtask

	task automatic send_rx(logic [7:0] b);
		req_item_t it;
		it = rand_req(CMD_RX);
		it.rx_byte = b;
		send_item(it);
	endtask

	task automatic send_tick();
		send_item(rand_req(CMD_TICK));
	endtask

	task automatic maybe_tick();
		if ($urandom_range(0, 3) == 0 && int'(sb.wait_ticks) + 1 < int'(sb.timeout))
			send_tick();
	endtask

	// Sender holds off until all expected beats are out, plus pipeline slack
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (sb.frame_beats.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic complete_txn();
		while (sb.ph != PH_IDLE)
			send_rx(8'($urandom));
	endtask

	task automatic timeout_run();
		send_item(rand_req($urandom_range(0, 1) ? CMD_READ : CMD_WRITE));
		if (sb.ph == PH_READ)
			repeat ($urandom_range(0, 3)) send_rx(8'($urandom));
		while (sb.ph != PH_IDLE)
			send_tick();
	endtask

	task automatic rand_sequence();
		int unsigned pick;
		logic [7:0] good;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			send_item(rand_req(CMD_READ));
			repeat (4) begin
				maybe_tick();
				send_rx(8'($urandom));
			end
			maybe_tick();
			good = sb.frame_csum(sb.run_sum);
			send_rx(($urandom_range(0, 4) == 0) ? 8'($urandom) : good);
		end else if (pick < 70) begin
			send_item(rand_req(CMD_WRITE));
			maybe_tick();
			good = sb.ack;
			send_rx(($urandom_range(0, 4) == 0) ? 8'($urandom) : good);
		end else if (pick < 80 && int'(sb.timeout) <= 50) begin
			timeout_run();
		end else if (pick < 90) begin
			// stray traffic while idle
			repeat ($urandom_range(1, 3))
				send_item(rand_req($urandom_range(0, 1) ? CMD_RX : CMD_TICK));
		end else begin
			// second request lands while the first is still pending
			send_item(rand_req($urandom_range(0, 1) ? CMD_READ : CMD_WRITE));
			send_item(rand_req($urandom_range(0, 1) ? CMD_READ : CMD_WRITE));
			complete_txn();
		end
	endtask

	task automatic run_phase(logic [15:0] base, logic [15:0] hdr, logic [15:0] wcmd,
		logic [15:0] tmo, int unsigned mode, int unsigned nseq);
		cfg_idx_t   order[4];
		logic [15:0] vals[4];
		int i;
		order = '{CFG_CSUM_BASE, CFG_HEADER, CFG_WR_CMD, CFG_TIMEOUT};
		vals = '{base, hdr, wcmd, tmo};
		for (i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= order[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
			sb.set_reg(order[i], vals[i]);
		end
		cfg_we <= 1'b0;
		idle_mode = mode;
		if (int'(tmo) <= 50)
			timeout_run();
		repeat (nseq) begin
			if ($urandom_range(0, 19) == 0)
				settle();
			rand_sequence();
		end
		complete_txn();
		settle();
	endtask

	initial begin
		req_item_t  it;
		logic [7:0] good;
		arst_n = 1'b0;
		idle_mode = 0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = '0;
		req_ch.command_code = '0;
		req_ch.reg_addr = '0;
		req_ch.write_data = '0;
		req_ch.rx_byte = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset config
		send_tick();
		send_rx(8'hFF);
		it = rand_req(CMD_READ);
		it.command_code = 8'hFF;
		it.reg_addr = 8'hFF;
		send_item(it);
		send_item(rand_req(CMD_WRITE));
		send_rx(8'hFF);
		send_rx(8'h00);
		send_rx(8'hA5);
		send_rx(8'h5A);
		send_rx(sb.frame_csum(sb.run_sum));
		it = rand_req(CMD_READ);
		it.command_code = 8'h00;
		it.reg_addr = 8'h80;
		send_item(it);
		repeat (4) send_rx(8'h00);
		good = sb.frame_csum(sb.run_sum);
		send_rx(good ^ 8'h01);
		it = rand_req(CMD_WRITE);
		it.reg_addr = 8'h7F;
		it.write_data = 32'hFFFF_FFFF;
		send_item(it);
		send_item(rand_req(CMD_READ));
		send_rx(sb.ack);
		it = rand_req(CMD_WRITE);
		it.reg_addr = 8'h00;
		it.write_data = 32'h0000_0000;
		send_item(it);
		send_rx(~sb.ack);
		send_item(rand_req(CMD_READ));
		send_tick();
		send_rx(8'h3C);
		complete_txn();
		settle();

		run_phase(16'h00FF, 16'h00FF, 16'h00FF, 16'd1, 0, 2);
		run_phase(16'h0000, 16'h0000, 16'h0000, 16'd0, 1, 2);
		run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'd6, 2, 3);
		run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'd3, 3, 3);
		run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'hFFFF, 0, 2);
		run_phase(16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom_range(8, 16)), 3, 3);
		run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'd100, 2, 2);

		complete_txn();
		settle();
		if (sb.errors == 0 && sb.frame_beats.size() == 0)
			$display("afe_uart_register_access_engine_unit test passed");
		else
			$display("afe_uart_register_access_engine_unit test failed");
		$finish;
	end

endmodule
